/* design/lfpe_pkg.sv */
// Shared types, codes and constants of the LED string frame pulse encoder.
package lfpe_pkg;

  // Frame layout and strand count
  localparam int NUM_STRANDS  = 8;
  localparam int STRAND_W     = 3;
  localparam int ADDR_W       = 6;
  localparam int INTEN_W      = 8;
  localparam int COLOR_W      = 12;
  localparam int FRAME_BITS   = ADDR_W + INTEN_W + COLOR_W;
  localparam int BITS_LEFT_W  = 5;
  localparam int TICK_W       = 8;

  // Stream widths
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 8;
  localparam int CFG_IDX_W = 3;

  // Command codes carried in s_tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Timing register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_LOW    = 3'd5;

  // Phase codes of the waveform sequencer
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_START    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BIT_LOW  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BIT_HIGH = 3'd3;
  localparam logic [PHASE_W-1:0] PH_END      = 3'd4;

  // Pulse timing, in ticks
  typedef struct packed {
    logic [TICK_W-1:0] start_high;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] end_low;
  } timing_t;

  // Result of one item
  typedef struct packed {
    logic                frame_done;
    logic                load_rejected;
    logic                busy_res;
    logic [STRAND_W-1:0] strand_select;
    logic                line_level;
  } result_t;

endpackage

/* design/led_string_frame_pulse_encoder.sv */
// Top level of the LED string frame pulse encoder: timing registers, stream ports.
// Takes one item per clock: a load (tuser 0) latches a 26-bit frame of address,
// intensity and color while idle; a tick (tuser 1) advances the wire waveform by
// one tick: start pulse high, each bit as low then high time, then a closing low
// gap. Every item yields exactly one result item, registered in the cycle after
// the item is taken; the input stalls only while that output register is full and
// not being taken. Timing registers are written on the config channel, which
// is always ready, and should change only while no frame is being sent.
module led_string_frame_pulse_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [2:0] strand, [8:3] bulb_address, [16:9] intensity, [28:17] color
  input  logic [lfpe_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] command
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] line_level, [3:1] strand_select, [4] busy_res, [5] load_rejected,
  // [6] frame_done
  output logic [lfpe_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfpe_pkg::TICK_W-1:0]    cfg_data
);
  import lfpe_pkg::*;

  localparam int ADDR_LO  = STRAND_W;
  localparam int INTEN_LO = ADDR_LO + ADDR_W;
  localparam int COLOR_LO = INTEN_LO + INTEN_W;

  timing_t timing;
  result_t res;
  logic    in_accept;

  // Accept while the output register is empty or being drained
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.start_high <= TICK_W'(10);
      timing.one_low    <= TICK_W'(20);
      timing.one_high   <= TICK_W'(8);
      timing.zero_low   <= TICK_W'(10);
      timing.zero_high  <= TICK_W'(20);
      timing.end_low    <= TICK_W'(30);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_HIGH: timing.start_high <= cfg_data;
        REG_ONE_LOW:    timing.one_low    <= cfg_data;
        REG_ONE_HIGH:   timing.one_high   <= cfg_data;
        REG_ZERO_LOW:   timing.zero_low   <= cfg_data;
        REG_ZERO_HIGH:  timing.zero_high  <= cfg_data;
        REG_END_LOW:    timing.end_low    <= cfg_data;
        default: ;
      endcase
    end
  end

  lfpe_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (in_accept),
    .command      (s_tuser[0]),
    .strand       (s_tdata[ADDR_LO-1:0]),
    .bulb_address (s_tdata[INTEN_LO-1:ADDR_LO]),
    .intensity    (s_tdata[COLOR_LO-1:INTEN_LO]),
    .color        (s_tdata[FRAME_BITS+STRAND_W-1:COLOR_LO]),
    .timing       (timing),
    .res          (res)
  );

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_tdata <= M_TDATA_W'(res);
    end
  end

endmodule

/* design/lfpe_seq.sv */
// Waveform sequencer: frame shift register, phase, bit and tick counters.
module lfpe_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          command,
  input  logic [lfpe_pkg::STRAND_W-1:0] strand,
  input  logic [lfpe_pkg::ADDR_W-1:0]   bulb_address,
  input  logic [lfpe_pkg::INTEN_W-1:0]  intensity,
  input  logic [lfpe_pkg::COLOR_W-1:0]  color,
  input  lfpe_pkg::timing_t             timing,
  output lfpe_pkg::result_t             res
);
  import lfpe_pkg::*;

  logic [PHASE_W-1:0]     phase, phase_next, phase_cur;
  logic [FRAME_BITS-1:0]  frame_shift, frame_shift_next;
  logic [BITS_LEFT_W-1:0] bits_left, bits_left_next, bits_dec;
  logic [TICK_W-1:0]      tick_count, tick_count_next, tick_inc, phase_len;
  logic [STRAND_W-1:0]    strand_reg, strand_reg_next;
  logic                   bit_one, strand_bad, rejected, done;

  // Treat unused phase codes as idle
  assign phase_cur  = (phase > PH_END) ? PH_IDLE : phase;
  assign bit_one    = frame_shift[FRAME_BITS-1];
  assign tick_inc   = tick_count + TICK_W'(1);
  assign bits_dec   = bits_left - BITS_LEFT_W'(1);
  assign strand_bad = {1'b0, strand} >= (STRAND_W+1)'(NUM_STRANDS);

  // Length of the current phase
  always_comb begin
    unique case (phase_cur)
      PH_START:    phase_len = timing.start_high;
      PH_BIT_LOW:  phase_len = bit_one ? timing.one_low : timing.zero_low;
      PH_BIT_HIGH: phase_len = bit_one ? timing.one_high : timing.zero_high;
      PH_END:      phase_len = timing.end_low;
      default:     phase_len = TICK_W'(1);
    endcase
  end

  // Next state for this item
  always_comb begin
    phase_next       = phase_cur;
    frame_shift_next = frame_shift;
    bits_left_next   = bits_left;
    tick_count_next  = tick_count;
    strand_reg_next  = strand_reg;
    rejected         = 1'b0;
    done             = 1'b0;
    if (command == CMD_LOAD) begin
      if (phase_cur != PH_IDLE || strand_bad) begin
        rejected = 1'b1;
      end else begin
        frame_shift_next = {bulb_address, intensity, color};
        bits_left_next   = BITS_LEFT_W'(FRAME_BITS);
        tick_count_next  = '0;
        strand_reg_next  = strand;
        phase_next       = PH_START;
      end
    end else if (phase_cur != PH_IDLE) begin
      if (tick_inc >= phase_len) begin
        tick_count_next = '0;
        unique case (phase_cur)
          PH_START:   phase_next = PH_BIT_LOW;
          PH_BIT_LOW: phase_next = PH_BIT_HIGH;
          PH_BIT_HIGH: begin
            frame_shift_next = {frame_shift[FRAME_BITS-2:0], 1'b0};
            bits_left_next   = bits_dec;
            phase_next       = (bits_dec == '0) ? PH_END : PH_BIT_LOW;
          end
          default: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        endcase
      end else begin
        tick_count_next = tick_inc;
      end
    end
  end

  // Result seen after this item
  always_comb begin
    res.line_level    = (phase_next == PH_START) || (phase_next == PH_BIT_HIGH);
    res.strand_select = strand_reg_next;
    res.busy_res      = phase_next != PH_IDLE;
    res.load_rejected = rejected;
    res.frame_done    = done;
  end

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      frame_shift <= '0;
      bits_left   <= '0;
      tick_count  <= '0;
      strand_reg  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      frame_shift <= frame_shift_next;
      bits_left   <= bits_left_next;
      tick_count  <= tick_count_next;
      strand_reg  <= strand_reg_next;
    end
  end

endmodule

/* design/lfpe_checker.sv */
// Port-level checker for the LED string frame pulse encoder, bound to the top.
module lfpe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lfpe_pkg::M_TDATA_W-1:0] m_tdata
);
  import lfpe_pkg::*;

  // An accepted item shows up as a result on the next cycle
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted item produced no result");

  // Input stalls only behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // A finished frame leaves the wire low and the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[6]) |-> (!m_tdata[0] && !m_tdata[4] && !m_tdata[5]))
    else $error("frame end with line high or busy");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind led_string_frame_pulse_encoder lfpe_checker u_lfpe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
